// ----- rtl/crc8fr_pkg.sv -----
// Package for the CRC-8 frame receiver.
// Holds byte types, header constants and the CRC-8/SMBus byte update.
// Used by every module of the block.
package crc8fr_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t HDR_FIRST  = 8'h06;
  localparam byte_t HDR_SECOND = 8'h85;
  localparam byte_t CRC_POLY   = 8'h07;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // held input beat between the input register and the frame core
  typedef struct packed {
    logic  valid;
    byte_t rx_byte;
  } held_t;

  // result fields as registered in the frame core
  typedef struct packed {
    logic  item_kind;
    byte_t byte_value;
    byte_t byte_position;
    logic  frame_good;
    byte_t crc_received;
    byte_t crc_computed;
  } result_t;

  // MSB-first CRC-8, poly 0x07, one byte per call
  function automatic byte_t crc8_byte(input byte_t crc, input byte_t b);
    byte_t c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/crc8fr_if.sv -----
// Valid/ready channel interfaces of the CRC-8 frame receiver.
// Input channel carries one received byte, result channel one result item.
// No dependencies.
interface crc8fr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crc8fr_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] byte_value;
  logic [7:0] byte_position;
  logic       frame_good;
  logic [7:0] crc_received;
  logic [7:0] crc_computed;

  modport source (output valid, output item_kind, output byte_value,
                  output byte_position, output frame_good,
                  output crc_received, output crc_computed, input ready);
  modport sink   (input valid, input item_kind, input byte_value,
                  input byte_position, input frame_good,
                  input crc_received, input crc_computed, output ready);
endinterface

// ----- rtl/crc8fr_in_stage.sv -----
// Input register of the CRC-8 frame receiver.
// Captures one byte per beat; depends on crc8fr_pkg and crc8fr_in_if.
module crc8fr_in_stage
  import crc8fr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  crc8fr_in_if.sink    in_if,
  input  logic         advance,
  output held_t        held
);

  logic  valid_r;
  byte_t byte_r;
  logic  take;

  assign in_if.ready = !valid_r || advance;
  assign take        = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_if.rx_byte;
    end
  end

  assign held.valid   = valid_r;
  assign held.rx_byte = byte_r;

endmodule

// ----- rtl/crc8fr_core.sv -----
// Frame state machine, CRC-8 accumulator and result register.
// Depends on crc8fr_pkg and crc8fr_out_if.
module crc8fr_core
  import crc8fr_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  held_t         held,
  input  byte_t         payload_length,
  output logic          advance,
  crc8fr_out_if.source  out_if
);

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_HDR2,
    ST_LEN,
    ST_DATA
  } state_t;

  state_t  state_r, state_nxt;
  byte_t   count_r, count_nxt;
  byte_t   crc_r, crc_nxt;
  logic    out_valid_r;
  result_t res_r, res_nxt;
  logic    emit;
  byte_t   b;

  assign b       = held.rx_byte;
  assign advance = held.valid && (!out_valid_r || out_if.ready);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    crc_nxt   = crc_r;
    emit      = 1'b0;
    res_nxt   = '0;
    unique case (state_r)
      ST_HUNT: begin
        if (b == HDR_FIRST) begin
          state_nxt = ST_HDR2;
        end
      end
      ST_HDR2: begin
        state_nxt = (b == HDR_SECOND) ? ST_LEN : ST_HUNT;
      end
      ST_LEN: begin
        if (b == payload_length) begin
          state_nxt = ST_DATA;
          count_nxt = '0;
          crc_nxt   = '0;
        end else begin
          state_nxt = ST_HUNT;
        end
      end
      ST_DATA: begin
        emit = 1'b1;
        if (count_r < payload_length) begin
          res_nxt.item_kind     = KIND_DATA;
          res_nxt.byte_value    = b;
          res_nxt.byte_position = count_r;
          crc_nxt               = crc8_byte(crc_r, b);
          count_nxt             = count_r + 8'd1;
        end else begin
          // CRC beat closes the frame
          res_nxt.item_kind    = KIND_END;
          res_nxt.frame_good   = (b == crc_r);
          res_nxt.crc_received = b;
          res_nxt.crc_computed = crc_r;
          state_nxt            = ST_HUNT;
          count_nxt            = '0;
          crc_nxt              = '0;
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      count_r     <= '0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        state_r     <= state_nxt;
        count_r     <= count_nxt;
        crc_r       <= crc_nxt;
        out_valid_r <= emit;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.item_kind     = res_r.item_kind;
  assign out_if.byte_value    = res_r.byte_value;
  assign out_if.byte_position = res_r.byte_position;
  assign out_if.frame_good    = res_r.frame_good;
  assign out_if.crc_received  = res_r.crc_received;
  assign out_if.crc_computed  = res_r.crc_computed;

endmodule

// ----- rtl/crc8_frame_receiver_unit.sv -----
// Top level of the CRC-8 frame receiver: header/length/CRC-8 deframer.
// Depends on crc8fr_pkg, crc8fr_if, crc8fr_in_stage and crc8fr_core.
//
//   channel   dir  handshake     payload
//   in_if     in   valid/ready   rx_byte
//   out_if    out  valid/ready   item_kind, byte_value, byte_position,
//                                frame_good, crc_received, crc_computed
//   cfg_      in   cfg_we        cfg_wdata -> payload_length
//
// One byte per cycle sustained while out_if.ready stays high; a beat's result
// is registered first in the input register, then in the result register.
// The CRC update and state decode sit between those two registers.
// rst_n is synchronous: state returns to the header hunt, length to 0.
// A stalled result holds the input register; in_if.ready drops only when
// both registers are full and out_if.ready is low.
module crc8_frame_receiver_unit
  import crc8fr_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  crc8fr_in_if.sink     in_if,
  crc8fr_out_if.source  out_if,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata
);

  byte_t payload_length_r;
  held_t held;
  logic  advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_length_r <= '0;
    end else if (cfg_we) begin
      payload_length_r <= cfg_wdata;
    end
  end

  crc8fr_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .advance (advance),
    .held    (held)
  );

  crc8fr_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .held           (held),
    .payload_length (payload_length_r),
    .advance        (advance),
    .out_if         (out_if)
  );

endmodule

// ----- verif/tb_crc8_frame_receiver_unit.sv -----
// Self-checking testbench for crc8_frame_receiver_unit: directed table, then random frames.
// Every result beat is checked against the directed table or a local deframer model.
// Depends on crc8fr_pkg, crc8fr_if and the RTL of the block.
module tb_crc8_frame_receiver_unit;
  import crc8fr_pkg::*;

  localparam int HOLD_CYCLES   = 80;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_BEATS   = 150;
  localparam int NUM_PHASES    = 8;

  typedef enum logic [1:0] {HUNT, GOT_SYNC1, GOT_SYNC2, IN_FRAME} rx_stage_t;
  typedef enum logic [1:0] {ROW_CFG, ROW_BYTE, ROW_CRC} row_op_t;

  typedef struct {
    row_op_t op;
    byte_t   val;
    bit      typed;
    result_t res;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  crc8fr_in_if  in_ch ();
  crc8fr_out_if out_ch ();

  crc8_frame_receiver_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // deframer model state
  rx_stage_t stage;
  byte_t     rx_count;
  byte_t     crc_acc;
  byte_t     len_reg;

  result_t   frame_items[$];
  int        errors;
  int        cycles;
  int        beats;
  bit        idle_on;
  bit        hold_req;
  dir_row_t  dir_rows [26];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic byte_t crc8_next(byte_t crc, byte_t b);
    byte_t c;
    logic  fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic bit deframe_byte(byte_t b, output result_t r);
    bit got;
    got = 1'b0;
    r   = '0;
    case (stage)
      HUNT: begin
        if (b == HDR_FIRST) stage = GOT_SYNC1;
      end
      GOT_SYNC1: begin
        stage = (b == HDR_SECOND) ? GOT_SYNC2 : HUNT;
      end
      GOT_SYNC2: begin
        if (b == len_reg) begin
          stage    = IN_FRAME;
          rx_count = '0;
          crc_acc  = '0;
        end else begin
          stage = HUNT;
        end
      end
      default: begin
        got = 1'b1;
        if (rx_count < len_reg) begin
          r.item_kind     = KIND_DATA;
          r.byte_value    = b;
          r.byte_position = rx_count;
          crc_acc         = crc8_next(crc_acc, b);
          rx_count        = rx_count + 8'd1;
        end else begin
          r.item_kind    = KIND_END;
          r.frame_good   = (b == crc_acc);
          r.crc_received = b;
          r.crc_computed = crc_acc;
          stage          = HUNT;
          rx_count       = '0;
          crc_acc        = '0;
        end
      end
    endcase
    return got;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t seen;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = '{out_ch.item_kind, out_ch.byte_value, out_ch.byte_position,
               out_ch.frame_good, out_ch.crc_received, out_ch.crc_computed};
      if (frame_items.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual %h",
                 $time, seen);
        errors++;
      end else begin
        want = frame_items.pop_front();
        check_field("item_kind", 8'(want.item_kind), 8'(seen.item_kind));
        check_field("byte_value", want.byte_value, seen.byte_value);
        check_field("byte_position", want.byte_position, seen.byte_position);
        check_field("frame_good", 8'(want.frame_good), 8'(seen.frame_good));
        check_field("crc_received", want.crc_received, seen.crc_received);
        check_field("crc_computed", want.crc_computed, seen.crc_computed);
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(99) < 32);
      end
    end
  end

  // called and returns at a falling edge
  task automatic offer(input byte_t b, input bit typed, input result_t typed_res);
    result_t r;
    bit      got;
    while (idle_on && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = deframe_byte(b, r);
    if (typed) frame_items.push_back(typed_res);
    else if (got) frame_items.push_back(r);
    beats++;
    @(negedge clk);
  endtask

  task automatic send(input byte_t b);
    offer(b, 1'b0, '0);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (frame_items.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input byte_t v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we  <= 1'b0;
    len_reg  = v;
  endtask

  task automatic random_chunk(input byte_t len);
    int    r;
    int    n;
    byte_t junk;
    r = $urandom_range(99);
    if (r < 70) begin
      send(HDR_FIRST);
      send(HDR_SECOND);
      send(len);
      for (int i = 0; i < len; i++) send(byte_t'($urandom_range(255)));
      if ($urandom_range(99) < 80) send(crc_acc);
      else send(byte_t'($urandom_range(255)));
    end else if (r < 80) begin
      n = $urandom_range(6, 1);
      repeat (n) send(byte_t'($urandom_range(255)));
    end else if (r < 90) begin
      junk = byte_t'($urandom_range(255));
      if (junk == HDR_SECOND) junk = ~junk;
      send(HDR_FIRST);
      send(junk);
    end else begin
      send(HDR_FIRST);
      send(HDR_SECOND);
      send(byte_t'(len + 8'd1 + byte_t'($urandom_range(254))));
    end
  endtask

  initial begin
    byte_t plen;
    int    start;
    bit    stalled;
    bit    paused;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    errors        = 0;
    cycles        = 0;
    beats         = 0;
    stalled       = 1'b0;
    paused        = 1'b0;
    stage         = HUNT;
    rx_count      = '0;
    crc_acc       = '0;
    len_reg       = '0;

    dir_rows = '{
      // bad second header byte, zero length, bad CRC
      '{ROW_BYTE, 8'h06, 1'b0, '0},
      '{ROW_BYTE, 8'h06, 1'b0, '0},
      '{ROW_BYTE, 8'h85, 1'b0, '0},
      '{ROW_BYTE, 8'h00, 1'b0, '0},
      '{ROW_BYTE, 8'h06, 1'b0, '0},
      '{ROW_BYTE, 8'h85, 1'b0, '0},
      '{ROW_BYTE, 8'h00, 1'b0, '0},
      '{ROW_BYTE, 8'hFF, 1'b1, '{KIND_END, 8'h00, 8'h00, 1'b0, 8'hFF, 8'h00}},
      // length mismatch, then a good two-byte frame
      '{ROW_CFG,  8'h02, 1'b0, '0},
      '{ROW_BYTE, 8'h06, 1'b0, '0},
      '{ROW_BYTE, 8'h85, 1'b0, '0},
      '{ROW_BYTE, 8'h03, 1'b0, '0},
      '{ROW_BYTE, 8'h06, 1'b0, '0},
      '{ROW_BYTE, 8'h85, 1'b0, '0},
      '{ROW_BYTE, 8'h02, 1'b0, '0},
      '{ROW_BYTE, 8'hFF, 1'b1, '{KIND_DATA, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00}},
      '{ROW_BYTE, 8'h00, 1'b1, '{KIND_DATA, 8'h00, 8'h01, 1'b0, 8'h00, 8'h00}},
      '{ROW_CRC,  8'h00, 1'b0, '0},
      // length shortened mid-frame: next byte is the CRC
      '{ROW_CFG,  8'h05, 1'b0, '0},
      '{ROW_BYTE, 8'h06, 1'b0, '0},
      '{ROW_BYTE, 8'h85, 1'b0, '0},
      '{ROW_BYTE, 8'h05, 1'b0, '0},
      '{ROW_BYTE, 8'hAA, 1'b0, '0},
      '{ROW_BYTE, 8'h55, 1'b0, '0},
      '{ROW_CFG,  8'h01, 1'b0, '0},
      '{ROW_CRC,  8'h00, 1'b0, '0}
    };

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].op)
        ROW_CFG: begin
          cfg_write(dir_rows[i].val);
        end
        ROW_BYTE: begin
          offer(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);
        end
        default: begin
          send(crc_acc);
        end
      endcase
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: plen = 8'd0;
        1: plen = 8'd255;
        2: plen = 8'd1;
        default: plen = byte_t'($urandom_range(16, 2));
      endcase
      cfg_write(plen);
      idle_on = (p != 3);
      start   = beats;
      while (beats - start < PHASE_BEATS) begin
        random_chunk(plen);
        if (p == 4 && !stalled) begin
          hold_req = 1'b1;
          stalled  = 1'b1;
        end
        if (p == 5 && !paused && beats - start > PHASE_BEATS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
    end

    idle_on = 1'b1;
    wait_idle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
